[rtl/core/cgr_pkg.sv]
// cgr_pkg: shared types and codes for the character generator.
// No dependencies; used by cgr_front, cgr_back and text_semigraphics_char_renderer.
`timescale 1ns / 1ps

package cgr_pkg;

  // Item kinds on the input channel
  typedef enum logic {
    ACT_RENDER = 1'b0,
    ACT_WRITE  = 1'b1
  } action_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PAPER    = 3'd0,
    REG_INK      = 3'd1,
    REG_INK_ALT  = 3'd2,
    REG_LC_EN    = 3'd3,
    REG_LC_FIRST = 3'd4,
    REG_LC_LAST  = 3'd5,
    REG_PALETTE  = 3'd6
  } reg_idx_t;

  localparam logic [7:0] LC_FIRST_RST = 8'd224;
  localparam logic [7:0] LC_LAST_RST  = 8'd255;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  paper;
    logic [7:0]  ink;
    logic [7:0]  ink_alt;
    logic        lc_en;
    logic [7:0]  lc_first;
    logic [7:0]  lc_last;
    logic [63:0] palette;
  } cfg_t;

  // Per-item info carried alongside the glyph store read
  typedef struct packed {
    logic       semi;      // semigraphic cell
    logic       row_zero;  // glyph row reads as blank
    logic [7:0] fg;
    logic [7:0] bg;
    logic       left;      // semigraphic left block set
    logic       right;     // semigraphic right block set
  } item_t;

  typedef logic [7:0][7:0] pix_vec_t;  // [i] is pixel i, 0 leftmost

endpackage

[rtl/core/cgr_glyph_ram.sv]
// cgr_glyph_ram: single-write, single-read glyph store with registered read.
// No package dependencies.
`timescale 1ns / 1ps

module cgr_glyph_ram #(
  parameter int DEPTH = 1536,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/cgr_front.sv]
// cgr_front: decodes a screen byte into colors, glyph address and block bits.
// Depends on cgr_pkg.
`timescale 1ns / 1ps

module cgr_front #(
  parameter int CELL_LINES    = 12,
  parameter int GLYPH_COUNT   = 128,
  parameter int LOWER_INVERTS = 0,
  parameter int AW            = 11
) (
  input  logic [7:0]     char_code,
  input  logic [3:0]     cell_line,
  input  logic           colour_set,
  input  cgr_pkg::cfg_t  cfg,
  output cgr_pkg::item_t info,
  output logic [AW-1:0]  rd_addr
);

  localparam logic [4:0]  LINES5   = 5'(CELL_LINES);
  localparam logic [5:0]  THIRD1   = 6'(CELL_LINES);
  localparam logic [5:0]  THIRD2   = 6'(2 * CELL_LINES);
  localparam logic [8:0]  GLYPHS9  = 9'(GLYPH_COUNT);
  localparam logic [11:0] LINES12  = 12'(CELL_LINES);
  localparam logic        LC_SWAP  = (LOWER_INVERTS != 0);

  logic        lc_hit;
  logic [6:0]  glyph;
  logic        swap;
  logic [7:0]  ink;
  logic [2:0]  pal_idx;
  logic [5:0]  line_x3;
  logic [11:0] addr_full;

  always_comb begin
    lc_hit  = cfg.lc_en && (char_code >= cfg.lc_first) && (char_code <= cfg.lc_last);
    glyph   = {lc_hit, char_code[5:0]};
    swap    = lc_hit ? LC_SWAP : char_code[7];
    ink     = colour_set ? cfg.ink_alt : cfg.ink;
    pal_idx = {colour_set, char_code[7:6]};
    line_x3 = {2'b00, cell_line} * 6'd3;

    info.semi     = char_code[6];
    info.row_zero = ({1'b0, cell_line} >= LINES5) || ({2'b00, glyph} >= GLYPHS9);
    info.left     = 1'b0;
    info.right    = 1'b0;

    if (char_code[6]) begin
      info.fg = cfg.palette[{pal_idx, 3'b000} +: 8];
      info.bg = cfg.paper;
      // block row 0/1/2 from the top third, middle third, bottom (clamped)
      if (line_x3 >= THIRD2) begin
        info.left  = char_code[1];
        info.right = char_code[0];
      end else if (line_x3 >= THIRD1) begin
        info.left  = char_code[3];
        info.right = char_code[2];
      end else begin
        info.left  = char_code[5];
        info.right = char_code[4];
      end
    end else if (swap) begin
      info.fg = cfg.paper;
      info.bg = ink;
    end else begin
      info.fg = ink;
      info.bg = cfg.paper;
    end

    addr_full = 12'(glyph) * LINES12 + 12'(cell_line);
    rd_addr   = addr_full[AW-1:0];
  end

endmodule

[rtl/core/cgr_back.sv]
// cgr_back: expands a glyph row or block pair into eight pixel values.
// Depends on cgr_pkg.
`timescale 1ns / 1ps

module cgr_back (
  input  cgr_pkg::item_t   info,
  input  logic [7:0]       row,
  output cgr_pkg::pix_vec_t pix
);

  logic [7:0] row_eff;

  always_comb begin
    row_eff = info.row_zero ? 8'h00 : row;
    for (int i = 0; i < 8; i++) begin
      if (info.semi) begin
        pix[i] = ((i < 4) ? info.left : info.right) ? info.fg : info.bg;
      end else begin
        pix[i] = row_eff[7 - i] ? info.fg : info.bg;
      end
    end
  end

endmodule

[rtl/core/text_semigraphics_char_renderer.sv]
// text_semigraphics_char_renderer: top level of the text/semigraphics-6 generator.
// Depends on cgr_pkg, cgr_glyph_ram, cgr_front, cgr_back.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+--------------------------------------
//  in_     | input     | in_valid / in_stall  | action, code, line, color set, glyph wr
//  out_    | output    | out_valid / out_stall| eight pixel values, pix_0 leftmost
//  cfg_    | input     | cfg_we               | register index and 64-bit data
//
//  One word per cycle sustained while out_stall is low. A render word goes through
//  two registers: the glyph store read register, loaded when the word is accepted,
//  then the output register, loaded when the read stage advances.
//  A glyph write word gives no output word and is visible to a render word accepted
//  in the very next cycle (single store port use per cycle).
//  rst_n is synchronous; it clears the valids and config. The store is not cleared.
//  out_stall backs up through the read stage to in_stall in the same cycle.
//
module text_semigraphics_char_renderer #(
  parameter int CELL_LINES    = 12,
  parameter int GLYPH_COUNT   = 128,
  parameter int LOWER_INVERTS = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_cell_line,
  input  logic        in_colour_set,
  input  logic [10:0] in_glyph_addr,
  input  logic [7:0]  in_glyph_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pix_0,
  output logic [7:0]  out_pix_1,
  output logic [7:0]  out_pix_2,
  output logic [7:0]  out_pix_3,
  output logic [7:0]  out_pix_4,
  output logic [7:0]  out_pix_5,
  output logic [7:0]  out_pix_6,
  output logic [7:0]  out_pix_7,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int          STORE_DEPTH = CELL_LINES * GLYPH_COUNT;
  localparam int          AW          = $clog2(STORE_DEPTH);
  localparam logic [12:0] DEPTH13     = 13'(STORE_DEPTH);

  // ---------------------------------------------------------------- config
  cgr_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        cgr_pkg::REG_PAPER:    cfg_nxt.paper    = cfg_wdata[7:0];
        cgr_pkg::REG_INK:      cfg_nxt.ink      = cfg_wdata[7:0];
        cgr_pkg::REG_INK_ALT:  cfg_nxt.ink_alt  = cfg_wdata[7:0];
        cgr_pkg::REG_LC_EN:    cfg_nxt.lc_en    = cfg_wdata[0];
        cgr_pkg::REG_LC_FIRST: cfg_nxt.lc_first = cfg_wdata[7:0];
        cgr_pkg::REG_LC_LAST:  cfg_nxt.lc_last  = cfg_wdata[7:0];
        cgr_pkg::REG_PALETTE:  cfg_nxt.palette  = cfg_wdata;
        default:               cfg_nxt = cfg_r;  // unused index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.paper    <= 8'h00;
      cfg_r.ink      <= 8'h00;
      cfg_r.ink_alt  <= 8'h00;
      cfg_r.lc_en    <= 1'b0;
      cfg_r.lc_first <= cgr_pkg::LC_FIRST_RST;
      cfg_r.lc_last  <= cgr_pkg::LC_LAST_RST;
      cfg_r.palette  <= 64'h0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------- handshake
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;      // read stage moves into the output register
  logic in_acc;
  logic render_acc;
  logic write_acc;

  assign s1_adv     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_adv;
  assign in_acc     = in_valid && !in_stall;
  assign render_acc = in_acc && (in_action == cgr_pkg::ACT_RENDER);
  assign write_acc  = in_acc && (in_action == cgr_pkg::ACT_WRITE);

  // ---------------------------------------------------------------- decode
  cgr_pkg::item_t front_info;
  logic [AW-1:0]  rd_addr;

  cgr_front #(
    .CELL_LINES   (CELL_LINES),
    .GLYPH_COUNT  (GLYPH_COUNT),
    .LOWER_INVERTS(LOWER_INVERTS),
    .AW           (AW)
  ) u_front (
    .char_code (in_char_code),
    .cell_line (in_cell_line),
    .colour_set(in_colour_set),
    .cfg       (cfg_r),
    .info      (front_info),
    .rd_addr   (rd_addr)
  );

  // ---------------------------------------------------------------- glyph store
  // Writes beyond the store are dropped. The read register only loads with the
  // read stage, so it holds its row while that stage is stalled.
  logic [11:0]   wa_ext;
  logic          wr_en;
  logic [7:0]    rd_row;

  assign wa_ext = {1'b0, in_glyph_addr};
  assign wr_en  = write_acc && ({2'b00, in_glyph_addr} < DEPTH13);

  cgr_glyph_ram #(
    .DEPTH(STORE_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wa_ext[AW-1:0]),
    .wdata(in_glyph_byte),
    .re   (render_acc),
    .raddr(rd_addr),
    .rdata(rd_row)
  );

  // ---------------------------------------------------------------- read stage
  cgr_pkg::item_t s1_info_r, s1_info_nxt;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_info_nxt  = s1_info_r;
    if (!in_stall) begin
      s1_valid_nxt = render_acc;
      if (render_acc) begin
        s1_info_nxt = front_info;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  cgr_pkg::pix_vec_t back_pix;
  cgr_pkg::pix_vec_t out_pix_r, out_pix_nxt;

  cgr_back u_back (
    .info(s1_info_r),
    .row (rd_row),
    .pix (back_pix)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        out_pix_nxt = back_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_info_r <= s1_info_nxt;
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pix_0 = out_pix_r[0];
  assign out_pix_1 = out_pix_r[1];
  assign out_pix_2 = out_pix_r[2];
  assign out_pix_3 = out_pix_r[3];
  assign out_pix_4 = out_pix_r[4];
  assign out_pix_5 = out_pix_r[5];
  assign out_pix_6 = out_pix_r[6];
  assign out_pix_7 = out_pix_r[7];

  // ---------------------------------------------------------------- checks
  // an accepted render word always occupies the read stage next cycle
  a_render_loads: assert property (@(posedge clk) disable iff (!rst_n)
    render_acc |=> s1_valid_r)
    else $error("render word lost before read stage");

  // a blocked read stage keeps its item info
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_info_r)))
    else $error("read stage changed while blocked");

  // a glyph write never occupies the pipeline
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (write_acc && !in_stall) |=> !s1_valid_r)
    else $error("glyph write produced a pipeline entry");

  // the read stage drains into the output register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("read stage advanced without output word");

endmodule
